/* src/gradient_color_map_core_assert.svh */
// Assertion macros used by the RTL core, gradient_color_map_core.
// Clock and reset are taken from the including module: i_clk, i_rst_n.
`ifndef GRADIENT_COLOR_MAP_CORE_ASSERT_SVH
`define GRADIENT_COLOR_MAP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define GCM_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define GCM_ASSERT(label, prop, msg)
`define GCM_ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* src/gcm_pkg.sv */
`default_nettype none
package gcm_pkg;

    localparam int LEVEL_W = 16;
    localparam int COLOR_W = 8;
    localparam int RATIO_W = LEVEL_W + 1;
    localparam int STEP_W  = $clog2(RATIO_W);
    localparam int ACC_W   = COLOR_W + RATIO_W + 1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic [COLOR_W-1:0]        red_in;
        logic [COLOR_W-1:0]        green_in;
        logic [COLOR_W-1:0]        blue_in;
        logic signed [LEVEL_W-1:0] level;
    } t_cmd_beat;

    typedef struct packed {
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               hit;
        logic               status;
    } t_res_beat;

    typedef struct packed {
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic signed [LEVEL_W-1:0] level;
    } t_stop;

    localparam int STOP_W = $bits(t_stop);

    // one quotient bit, MSB first
    typedef struct packed {
        logic valid;
        logic q;
    } t_qbit;

endpackage
`default_nettype wire

/* src/gcm_cmd_if.sv */
`default_nettype none
interface gcm_cmd_if;
    logic                 valid;
    logic                 ready;
    gcm_pkg::t_cmd_beat   beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface
`default_nettype wire

/* src/gcm_res_if.sv */
`default_nettype none
interface gcm_res_if;
    logic                 valid;
    logic                 ready;
    gcm_pkg::t_res_beat   beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface
`default_nettype wire

/* src/gradient_color_map_core.sv */
// channel | dir | payload                                    | beat rule
// i_cmd   | in  | command, red_in, green_in, blue_in, level  | valid && ready
// o_res   | out | red_out, green_out, blue_out, hit, status  | valid && ready
//
// Clear, refused add, short table: straight from accept to the result state.
// Add: a read and a compare per stop moved up, one more pair unless the stop lands at entry 0, then the write.
// Query: reads stops in order; a hit adds a serial divide of 17 steps before the result.
// Reset clears the stop count, state and output valid; table contents are left as they are.
// i_cmd is taken only when the sequencer is idle; a result waiting on o_res
//   does not block the next beat, which then stalls at its own result.
`default_nettype none
`include "gradient_color_map_core_assert.svh"
module gradient_color_map_core #(
    parameter int MAX_STOPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcm_cmd_if.sink    i_cmd,
    gcm_res_if.source  o_res
);
    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int LW = gcm_pkg::LEVEL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_WR,
        S_Q_RD0,
        S_SCAN,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_pos;
    logic               r_first;
    gcm_pkg::t_cmd_beat r_cmd;
    gcm_pkg::t_stop     r_prev;
    gcm_pkg::t_res_beat r_pend;
    gcm_pkg::t_res_beat r_out_beat;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_refuse;
    logic               w_in_add;
    logic               w_res_flags;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    gcm_pkg::t_stop     w_wdata;
    logic [AW-1:0]      w_raddr;
    gcm_pkg::t_stop     w_rdata;
    gcm_pkg::t_stop     w_new;
    logic               w_shift;
    logic               w_lo_ok;
    logic               w_hi_ok;
    logic               w_last;
    logic               w_div_start;
    logic               w_div_done;
    logic [LW-1:0]      w_num;
    logic [LW-1:0]      w_span;
    gcm_pkg::t_qbit     w_q;
    logic [gcm_pkg::COLOR_W-1:0] w_red;
    logic [gcm_pkg::COLOR_W-1:0] w_green;
    logic [gcm_pkg::COLOR_W-1:0] w_blue;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_out_load = (r_state == S_OUT) && w_out_free;
    assign w_refuse   = (i_cmd.beat.command == gcm_pkg::CMD_ADD) &&
                        (r_count == CW'(MAX_STOPS));
    assign w_in_add   = (r_state == S_ADD_CMP) || (r_state == S_ADD_WR);
    assign w_res_flags = r_out_beat.hit && r_out_beat.status;

    assign w_new.red   = r_cmd.red_in;
    assign w_new.green = r_cmd.green_in;
    assign w_new.blue  = r_cmd.blue_in;
    assign w_new.level = r_cmd.level;

    assign w_shift = $signed(w_rdata.level) > $signed(r_cmd.level);
    assign w_lo_ok = $signed(r_prev.level) <= $signed(r_cmd.level);
    assign w_hi_ok = $signed(r_cmd.level) <= $signed(w_rdata.level);
    assign w_last  = (CW'(r_pos) + CW'(1)) == r_count;
    assign w_num   = r_cmd.level - r_prev.level;
    assign w_span  = w_rdata.level - r_prev.level;

    assign w_div_start = (r_state == S_SCAN) && !r_first && w_lo_ok && w_hi_ok;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = w_rdata;
        w_raddr = r_pos;
        case (r_state)
            S_ADD_RD:  w_raddr = r_pos - AW'(1);
            S_ADD_CMP: w_we    = w_shift;
            S_ADD_WR: begin
                w_we    = 1'b1;
                w_wdata = w_new;
            end
            S_Q_RD0:   w_raddr = '0;
            S_SCAN:    w_raddr = r_pos + AW'(1);
            default: ;
        endcase
    end

    gcm_ram #(
        .WIDTH (gcm_pkg::STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_span),
        .o_q     (w_q),
        .o_done  (w_div_done)
    );

    gcm_blend u_blend_red (
        .i_clk   (i_clk),
        .i_start (w_div_start),
        .i_c1    (r_prev.red),
        .i_c2    (w_rdata.red),
        .i_q     (w_q),
        .o_color (w_red)
    );

    gcm_blend u_blend_green (
        .i_clk   (i_clk),
        .i_start (w_div_start),
        .i_c1    (r_prev.green),
        .i_c2    (w_rdata.green),
        .i_q     (w_q),
        .o_color (w_green)
    );

    gcm_blend u_blend_blue (
        .i_clk   (i_clk),
        .i_start (w_div_start),
        .i_c1    (r_prev.blue),
        .i_c2    (w_rdata.blue),
        .i_q     (w_q),
        .o_color (w_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_beat  <= r_pend;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_cmd.beat;
                        r_pend  <= {{(3 * gcm_pkg::COLOR_W + 1){1'b0}}, w_refuse};
                        r_first <= 1'b1;
                        case (i_cmd.beat.command)
                            gcm_pkg::CMD_ADD: begin
                                if (r_count == CW'(MAX_STOPS)) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_pos   <= AW'(r_count);
                                    r_state <= (r_count == '0) ? S_ADD_WR : S_ADD_RD;
                                end
                            end
                            gcm_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_OUT;
                            end
                            gcm_pkg::CMD_QUERY: begin
                                r_state <= (r_count < CW'(2)) ? S_OUT : S_Q_RD0;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_ADD_RD: r_state <= S_ADD_CMP;
                S_ADD_CMP: begin
                    if (w_shift) begin
                        r_pos   <= r_pos - AW'(1);
                        r_state <= (r_pos == AW'(1)) ? S_ADD_WR : S_ADD_RD;
                    end else begin
                        r_state <= S_ADD_WR;
                    end
                end
                S_ADD_WR: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end
                S_Q_RD0: begin
                    r_pos   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    r_prev  <= w_rdata;
                    r_pos   <= r_pos + AW'(1);
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else if (w_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_pend.red_out   <= w_red;
                    r_pend.green_out <= w_green;
                    r_pend.blue_out  <= w_blue;
                    r_pend.hit       <= 1'b1;
                    r_state          <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE) && i_rst_n;
    assign o_res.valid = r_out_valid;
    assign o_res.beat  = r_out_beat;

    `GCM_ASSERT(a_busy_after_accept, w_accept |=> !i_cmd.ready, "ready held after accept")
    `GCM_ASSERT(a_count_range, r_count <= CW'(MAX_STOPS), "stop count beyond table size")
    `GCM_ASSERT_NEVER(a_we_outside_add, w_we && !w_in_add, "table write outside add")
    `GCM_ASSERT_NEVER(a_hit_and_status, r_out_valid && w_res_flags, "hit with refused status")
    `GCM_ASSERT(a_done_in_div, w_div_done |-> r_state == S_DIV, "divider done outside S_DIV")
endmodule
`default_nettype wire

/* src/gcm_ram.sv */
`default_nettype none
module gcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* src/gcm_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient = floor((num << 16) / den), zero when den is zero; num <= den.
module gcm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gcm_pkg::LEVEL_W-1:0]   i_num,
    input  logic [gcm_pkg::LEVEL_W-1:0]   i_den,
    output gcm_pkg::t_qbit                o_q,
    output logic                          o_done
);
    localparam int LW = gcm_pkg::LEVEL_W;
    localparam int SW = gcm_pkg::STEP_W;

    logic [LW:0]   r_rem;
    logic [LW-1:0] r_den;
    logic          r_zero;
    logic          r_busy;
    logic [SW-1:0] r_cnt;

    logic          w_ge;
    logic [LW:0]   w_sub;
    logic [LW:0]   w_sel;

    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_sub = r_rem - {1'b0, r_den};
    assign w_sel = w_ge ? w_sub : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_zero <= (i_den == '0);
            r_cnt  <= SW'(gcm_pkg::RATIO_W - 1);
        end else if (r_busy) begin
            r_rem <= {w_sel[LW-1:0], 1'b0};
            r_cnt <= r_cnt - SW'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_q.valid = r_busy;
    assign o_q.q     = r_busy && w_ge && !r_zero;
    assign o_done    = r_busy && (r_cnt == '0);
endmodule
`default_nettype wire

/* src/gcm_blend.sv */
`default_nettype none
// Shift-add blend: c1 + ((c2 - c1) * ratio) >> 16, ratio bits arrive MSB first.
module gcm_blend (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic [gcm_pkg::COLOR_W-1:0]   i_c1,
    input  logic [gcm_pkg::COLOR_W-1:0]   i_c2,
    input  gcm_pkg::t_qbit                i_q,
    output logic [gcm_pkg::COLOR_W-1:0]   o_color
);
    localparam int CW = gcm_pkg::COLOR_W;
    localparam int AW = gcm_pkg::ACC_W;
    localparam int FW = gcm_pkg::RATIO_W - 1;

    logic [CW-1:0]        r_c1;
    logic signed [CW:0]   r_diff;
    logic signed [AW-1:0] r_acc;

    logic signed [AW-1:0] w_diff_ext;
    logic signed [AW-1:0] w_sum;

    assign w_diff_ext = {{(AW-CW-1){r_diff[CW]}}, r_diff};
    assign w_sum      = $signed({{(AW-CW-FW){1'b0}}, r_c1, {FW{1'b0}}}) + r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_c1   <= i_c1;
            r_diff <= $signed({1'b0, i_c2}) - $signed({1'b0, i_c1});
            r_acc  <= '0;
        end else if (i_q.valid) begin
            r_acc <= (r_acc <<< 1) + (i_q.q ? w_diff_ext : '0);
        end
    end

    assign o_color = w_sum[FW+CW-1:FW];
endmodule
`default_nettype wire
